>>> rtl/core/fstf_pkg.sv
// Shared types, constants and arithmetic helpers for the similarity-transform fit unit.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package fstf_pkg;

  localparam int NUM_POINTS_DEF = 5;
  localparam int NUM_POINTS_MAX = 8;
  localparam int NUM_REF        = 5;
  localparam int COORD_W        = 16;
  localparam int REF_W          = 23;
  localparam int MAXLOG         = $clog2(NUM_POINTS_MAX);
  localparam int SX_W           = COORD_W + MAXLOG;
  localparam int SQ_W           = 2 * COORD_W + 1 + MAXLOG;
  localparam int CC_W           = COORD_W + REF_W + 1 + MAXLOG;
  localparam int CS_W           = CC_W + 1;
  localparam int PROD_W         = COORD_W + REF_W;
  localparam int OFF_W          = 8;
  localparam int COEF_W         = 32;
  localparam int WIDE_W         = 64;

  localparam logic [OFF_W-1:0] OFF_RESET = 8'd8;

  localparam logic [REF_W-1:0] REF_U [NUM_REF] = '{
    23'd1985387, 23'd4294692, 23'd3147380, 23'd2198687, 23'd4111067
  };
  localparam logic [REF_W-1:0] REF_V [NUM_REF] = '{
    23'd3387969, 23'd3375196, 23'd4701330, 23'd6053265, 23'd6042688
  };

  typedef struct packed {
    logic [SX_W-1:0]        sx;
    logic [SX_W-1:0]        sy;
    logic [SQ_W-1:0]        ssq;
    logic [CC_W-1:0]        scc;
    logic signed [CS_W-1:0] scs;
    logic [OFF_W-1:0]       off;
  } set_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] quo;
    logic [WIDE_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] fwd_a;
    logic signed [COEF_W-1:0] fwd_b;
    logic signed [COEF_W-1:0] fwd_tx;
    logic signed [COEF_W-1:0] fwd_ty;
    logic signed [COEF_W-1:0] inv_a;
    logic signed [COEF_W-1:0] inv_b;
    logic signed [COEF_W-1:0] inv_tx;
    logic signed [COEF_W-1:0] inv_ty;
    logic                     degenerate;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic                     sat;
    logic signed [COEF_W-1:0] val;
  } clip_t;

  function automatic logic [WIDE_W-1:0] ref_sum(input logic use_v, input int n);
    logic [WIDE_W-1:0] s;
    s = '0;
    for (int i = 0; i < n; i++) begin
      s = s + WIDE_W'(use_v ? REF_V[i % NUM_REF] : REF_U[i % NUM_REF]);
    end
    return s;
  endfunction

  function automatic logic [WIDE_W-1:0] mag64(input logic signed [WIDE_W-1:0] v);
    return v[WIDE_W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic clip_t clip32(input logic neg, input logic [WIDE_W-1:0] mag);
    clip_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'sh8000_0000;
      end else begin
        r.val = COEF_W'(64'd0 - mag);
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'sh7FFF_FFFF;
      end else begin
        r.val = mag[COEF_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic clip_t q16(input logic signed [WIDE_W-1:0] s);
    logic [WIDE_W-1:0] m;
    m = mag64(s);
    m = (m >> 16) + {63'd0, m[15]};
    return clip32(s[WIDE_W-1], m);
  endfunction

endpackage

>>> rtl/core/fstf_front.sv
// Front end: accepts landmark requests, accumulates the per-set sums with one shared
// multiplier and pushes a finished set into the queue. Uses fstf_pkg.
`timescale 1ns / 1ps

module fstf_front #(
  parameter int NUM_POINTS = fstf_pkg::NUM_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fstf_pkg::COORD_W-1:0]         x_coord,
  input  logic [fstf_pkg::COORD_W-1:0]         y_coord,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fstf_pkg::OFF_W-1:0]           cfg_data,
  input  logic                                 q_full,
  output logic                                 q_push,
  output fstf_pkg::set_t                       q_data
);
  import fstf_pkg::*;

  localparam int CNT_W = (NUM_POINTS > 2) ? $clog2(NUM_POINTS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_POINTS - 1);
  localparam logic [2:0] STEP_LAST = 3'd6;
  localparam logic [2:0] RIDX_LAST = 3'(NUM_REF - 1);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_RUN  = 2'b10
  } fstate_t;

  fstate_t                state_r, state_nxt;
  logic [2:0]             step_r, step_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [2:0]             ridx_r, ridx_nxt;
  logic [COORD_W-1:0]     x_r, y_r;
  logic [OFF_W-1:0]       off_r;
  logic [PROD_W-1:0]      prod_r;
  logic [SX_W-1:0]        sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SQ_W-1:0]        ssq_r, ssq_nxt;
  logic [CC_W-1:0]        scc_r, scc_nxt;
  logic signed [CS_W-1:0] scs_r, scs_nxt;
  logic [COORD_W-1:0]     op_a;
  logic [REF_W-1:0]       op_b;
  logic                   accept;

  assign busy      = (state_r == F_RUN) || q_full;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    op_a = x_r;
    op_b = '0;
    case (step_r)
      3'd0: begin op_a = x_r; op_b = REF_U[ridx_r]; end
      3'd1: begin op_a = y_r; op_b = REF_V[ridx_r]; end
      3'd2: begin op_a = x_r; op_b = REF_W'(x_r); end
      3'd3: begin op_a = y_r; op_b = REF_W'(y_r); end
      3'd4: begin op_a = y_r; op_b = REF_U[ridx_r]; end
      3'd5: begin op_a = x_r; op_b = REF_V[ridx_r]; end
      default: begin op_a = x_r; op_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    ridx_nxt  = ridx_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    ssq_nxt   = ssq_r;
    scc_nxt   = scc_r;
    scs_nxt   = scs_r;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_RUN;
          step_nxt  = '0;
          sx_nxt    = sx_r + SX_W'(x_coord);
          sy_nxt    = sy_r + SX_W'(y_coord);
        end
      end
      F_RUN: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd1, 3'd2: scc_nxt = scc_r + CC_W'(prod_r);
          3'd3, 3'd4: ssq_nxt = ssq_r + SQ_W'(prod_r);
          3'd5: scs_nxt = scs_r + $signed(CS_W'(prod_r));
          3'd6: scs_nxt = scs_r - $signed(CS_W'(prod_r));
          default: ;
        endcase
        if (step_r == STEP_LAST) begin
          state_nxt = F_IDLE;
          if (cnt_r == CNT_LAST) begin
            q_push  = 1'b1;
            cnt_nxt = '0;
            ridx_nxt = '0;
          end else begin
            cnt_nxt  = cnt_r + CNT_W'(1);
            ridx_nxt = (ridx_r == RIDX_LAST) ? 3'd0 : ridx_r + 3'd1;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_data = '{sx: sx_nxt, sy: sy_nxt, ssq: ssq_nxt, scc: scc_nxt, scs: scs_nxt,
                    off: off_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      ridx_r  <= '0;
      off_r   <= OFF_RESET;
      sx_r    <= '0;
      sy_r    <= '0;
      ssq_r   <= '0;
      scc_r   <= '0;
      scs_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      ridx_r  <= ridx_nxt;
      if (cfg_valid) begin
        off_r <= cfg_data;
      end
      if (q_push) begin
        sx_r  <= '0;
        sy_r  <= '0;
        ssq_r <= '0;
        scc_r <= '0;
        scs_r <= '0;
      end else begin
        sx_r  <= sx_nxt;
        sy_r  <= sy_nxt;
        ssq_r <= ssq_nxt;
        scc_r <= scc_nxt;
        scs_r <= scs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= x_coord;
      y_r <= y_coord;
    end
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

>>> rtl/core/fstf_fifo.sv
// Two-entry queue of finished landmark sets between the front end and the fit engine.
// Uses fstf_pkg for the entry type.
`timescale 1ns / 1ps

module fstf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fstf_pkg::set_t din,
  output logic           full,
  input  logic           pop,
  output fstf_pkg::set_t dout,
  output logic           empty
);
  import fstf_pkg::*;

  set_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> rtl/core/fstf_div.sv
// Shared 64-bit restoring divider, one quotient bit per cycle.
// Uses fstf_pkg for the request and response structs.
`timescale 1ns / 1ps

module fstf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fstf_pkg::div_req_t req,
  output fstf_pkg::div_rsp_t rsp
);
  import fstf_pkg::*;

  logic              run_r, done_r;
  logic [5:0]        cnt_r;
  logic [WIDE_W-1:0] quo_r, rem_r, den_r;
  logic [WIDE_W:0]   sh, diff;

  assign sh   = {rem_r, quo_r[WIDE_W-1]};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (run_r) begin
      if (!diff[WIDE_W]) begin
        rem_r <= diff[WIDE_W-1:0];
        quo_r <= {quo_r[WIDE_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[WIDE_W-1:0];
        quo_r <= {quo_r[WIDE_W-2:0], 1'b0};
      end
    end
  end

  assign rsp = '{done: done_r, quo: quo_r, rem: rem_r};

endmodule

>>> rtl/core/fstf_back.sv
// Fit engine: sequences the least-squares solve and the inverse over one shared
// multiplier and the shared divider. Uses fstf_pkg and fstf_div.
`timescale 1ns / 1ps

module fstf_back #(
  parameter int NUM_POINTS = fstf_pkg::NUM_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  fstf_pkg::set_t    q_head,
  output logic              q_pop,
  output fstf_pkg::result_t res,
  output logic              res_valid
);
  import fstf_pkg::*;

  localparam logic signed [WIDE_W-1:0] N64   = WIDE_W'(NUM_POINTS);
  localparam logic signed [WIDE_W-1:0] SU64  = ref_sum(1'b0, NUM_POINTS);
  localparam logic signed [WIDE_W-1:0] SV64  = ref_sum(1'b1, NUM_POINTS);
  localparam logic [WIDE_W-1:0]        DIVN  = WIDE_W'(16 * NUM_POINTS);

  localparam logic [2:0] DV_A  = 3'd0;
  localparam logic [2:0] DV_B  = 3'd1;
  localparam logic [2:0] DV_TX = 3'd2;
  localparam logic [2:0] DV_TY = 3'd3;
  localparam logic [2:0] DV_IA = 3'd4;
  localparam logic [2:0] DV_IB = 3'd5;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOAD   = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_ACC    = 7'b0001000,
    ST_DSTART = 7'b0010000,
    ST_DWAIT  = 7'b0100000,
    ST_OUT    = 7'b1000000
  } bstate_t;

  bstate_t                  state_r, state_nxt;
  logic [4:0]               step_r, step_nxt;
  logic [2:0]               sel_r, sel_nxt;
  logic signed [WIDE_W-1:0] su_r, su_nxt, c_r, c_nxt, d_r, d_nxt, den_r, den_nxt;
  logic signed [WIDE_W-1:0] anum_r, anum_nxt, bnum_r, bnum_nxt, t_r, t_nxt;
  logic signed [65:0]       prod_r;
  logic signed [WIDE_W-1:0] p;
  result_t                  res_r, res_nxt;
  logic                     valid_r, valid_nxt;
  logic signed [32:0]       op_a, op_b, sx33, sy33, off33, su33, sv33;
  logic signed [32:0]       a33, b33, tx33, ty33, ia33, ib33, am33, bm33;
  logic [COEF_W-1:0]        am, bm;
  logic [WIDE_W-1:0]        num_w, den_w, q_w;
  logic                     neg_w;
  clip_t                    cl, cq;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  fstf_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign p     = prod_r[WIDE_W-1:0];
  assign am    = res_r.fwd_a[COEF_W-1] ? (~res_r.fwd_a + 32'd1) : res_r.fwd_a;
  assign bm    = res_r.fwd_b[COEF_W-1] ? (~res_r.fwd_b + 32'd1) : res_r.fwd_b;
  assign sx33  = $signed({14'd0, q_head.sx});
  assign sy33  = $signed({14'd0, q_head.sy});
  assign off33 = $signed({9'd0, q_head.off, 16'd0});
  assign su33  = su_r[32:0];
  assign sv33  = SV64[32:0];
  assign a33   = {res_r.fwd_a[COEF_W-1], res_r.fwd_a};
  assign b33   = {res_r.fwd_b[COEF_W-1], res_r.fwd_b};
  assign tx33  = {res_r.fwd_tx[COEF_W-1], res_r.fwd_tx};
  assign ty33  = {res_r.fwd_ty[COEF_W-1], res_r.fwd_ty};
  assign ia33  = {res_r.inv_a[COEF_W-1], res_r.inv_a};
  assign ib33  = {res_r.inv_b[COEF_W-1], res_r.inv_b};
  assign am33  = $signed({1'b0, am});
  assign bm33  = $signed({1'b0, bm});

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      5'd0:  begin op_a = off33; op_b = sx33; end
      5'd1:  begin op_a = off33; op_b = sy33; end
      5'd2:  begin op_a = sx33;  op_b = sx33; end
      5'd3:  begin op_a = sy33;  op_b = sy33; end
      5'd4:  begin op_a = sx33;  op_b = su33; end
      5'd5:  begin op_a = sy33;  op_b = sv33; end
      5'd6:  begin op_a = sy33;  op_b = su33; end
      5'd7:  begin op_a = sx33;  op_b = sv33; end
      5'd8:  begin op_a = sx33;  op_b = a33;  end
      5'd9:  begin op_a = sy33;  op_b = b33;  end
      5'd10: begin op_a = sy33;  op_b = a33;  end
      5'd11: begin op_a = sx33;  op_b = b33;  end
      5'd12: begin op_a = am33;  op_b = am33; end
      5'd13: begin op_a = bm33;  op_b = bm33; end
      5'd14: begin op_a = ia33;  op_b = tx33; end
      5'd15: begin op_a = ib33;  op_b = ty33; end
      5'd16: begin op_a = ib33;  op_b = tx33; end
      5'd17: begin op_a = ia33;  op_b = ty33; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    num_w = '0;
    den_w = DIVN;
    neg_w = 1'b0;
    unique case (sel_r)
      DV_A: begin
        num_w = mag64(anum_r <<< 4);
        den_w = den_r;
        neg_w = anum_r[WIDE_W-1];
      end
      DV_B: begin
        num_w = mag64(bnum_r <<< 4);
        den_w = den_r;
        neg_w = bnum_r[WIDE_W-1];
      end
      DV_TX, DV_TY: begin
        num_w = mag64(t_r);
        den_w = DIVN;
        neg_w = t_r[WIDE_W-1];
      end
      DV_IA: begin
        num_w = {am, 32'd0};
        den_w = t_r;
        neg_w = res_r.fwd_a[COEF_W-1];
      end
      DV_IB: begin
        num_w = {bm, 32'd0};
        den_w = t_r;
        neg_w = !res_r.fwd_b[COEF_W-1] && (res_r.fwd_b != '0);
      end
      default: begin
        num_w = '0;
        den_w = DIVN;
        neg_w = 1'b0;
      end
    endcase
  end

  assign q_w = div_rsp.quo + WIDE_W'(div_rsp.rem >= (den_w - div_rsp.rem));
  assign cl  = clip32(neg_w, q_w);
  assign div_req = '{start: (state_r == ST_DSTART), num: num_w, den: den_w};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sel_nxt   = sel_r;
    su_nxt    = su_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    den_nxt   = den_r;
    anum_nxt  = anum_r;
    bnum_nxt  = bnum_r;
    t_nxt     = t_r;
    res_nxt   = res_r;
    valid_nxt = 1'b0;
    q_pop     = 1'b0;
    cq        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        su_nxt    = SU64 + ((WIDE_W'(q_head.off) * N64) <<< 16);
        res_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        step_nxt  = step_r + 5'd1;
        state_nxt = ST_MUL;
        case (step_r)
          5'd0:  c_nxt = $signed(WIDE_W'(q_head.scc)) + p;
          5'd1:  d_nxt = {{(WIDE_W-CS_W){q_head.scs[CS_W-1]}}, q_head.scs} + p;
          5'd2:  den_nxt = $signed(WIDE_W'(q_head.ssq)) * N64 - p;
          5'd3:  den_nxt = den_r - p;
          5'd4:  anum_nxt = c_r * N64 - p;
          5'd5:  anum_nxt = anum_r - p;
          5'd6:  bnum_nxt = d_r * N64 - p;
          5'd7: begin
            bnum_nxt = bnum_r + p;
            if (den_r <= 64'sd0) begin
              res_nxt.degenerate = 1'b1;
              state_nxt = ST_OUT;
            end else begin
              sel_nxt   = DV_A;
              state_nxt = ST_DSTART;
            end
          end
          5'd8:  t_nxt = (su_r <<< 4) - p;
          5'd9: begin
            t_nxt     = t_r - p;
            sel_nxt   = DV_TX;
            state_nxt = ST_DSTART;
          end
          5'd10: t_nxt = (SV64 <<< 4) - p;
          5'd11: begin
            t_nxt     = t_r + p;
            sel_nxt   = DV_TY;
            state_nxt = ST_DSTART;
          end
          5'd12: t_nxt = p;
          5'd13: begin
            t_nxt = t_r + p;
            if (t_nxt == '0) begin
              state_nxt = ST_OUT;
            end else begin
              sel_nxt   = DV_IA;
              state_nxt = ST_DSTART;
            end
          end
          5'd14: t_nxt = 64'sd0 - p;
          5'd15: begin
            t_nxt = t_r - p;
            cq    = q16(t_nxt);
            res_nxt.inv_tx    = cq.val;
            res_nxt.saturated = res_r.saturated | cq.sat;
          end
          5'd16: t_nxt = p;
          5'd17: begin
            t_nxt = t_r - p;
            cq    = q16(t_nxt);
            res_nxt.inv_ty    = cq.val;
            res_nxt.saturated = res_r.saturated | cq.sat;
            state_nxt = ST_OUT;
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_DSTART: begin
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          res_nxt.saturated = res_r.saturated | cl.sat;
          state_nxt = ST_MUL;
          unique case (sel_r)
            DV_A: begin
              res_nxt.fwd_a = cl.val;
              sel_nxt   = DV_B;
              state_nxt = ST_DSTART;
            end
            DV_B: begin
              res_nxt.fwd_b = cl.val;
              step_nxt = 5'd8;
            end
            DV_TX: begin
              res_nxt.fwd_tx = cl.val;
              step_nxt = 5'd10;
            end
            DV_TY: begin
              res_nxt.fwd_ty = cl.val;
              step_nxt = 5'd12;
            end
            DV_IA: begin
              res_nxt.inv_a = cl.val;
              sel_nxt   = DV_IB;
              state_nxt = ST_DSTART;
            end
            DV_IB: begin
              res_nxt.inv_b = cl.val;
              step_nxt = 5'd14;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        valid_nxt = 1'b1;
        q_pop     = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    sel_r  <= sel_nxt;
    su_r   <= su_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    den_r  <= den_nxt;
    anum_r <= anum_nxt;
    bnum_r <= bnum_nxt;
    t_r    <= t_nxt;
    res_r  <= res_nxt;
    prod_r <= op_a * op_b;
  end

  assign res       = res_r;
  assign res_valid = valid_r;

endmodule

>>> rtl/core/face_similarity_transform_fit_unit.sv
// Top level of the five-point similarity-transform fit unit.
// Instantiates fstf_front, fstf_fifo and fstf_back; uses fstf_pkg.
//
// Usage:
//   Landmark requests enter on start/busy: a request is taken at a clock edge with
//   start high and busy low. Each request occupies the front end for its accept cycle
//   and while six products pass through the one shared multiplier.
//   The offset register is written on cfg_valid/cfg_ready; cfg_ready is always high.
//   After the last point of a set, the sums go into a two-entry queue and the fit
//   engine solves them with up to six passes of the one-bit-per-cycle divider and
//   up to 18 multiply steps on the shared multiplier.
//   The result appears for exactly one cycle with out_valid high; the receiver
//   cannot stall, so nothing waits on the output side. busy rises while the queue is
//   full, so sets arriving faster than the engine drains them are held off.
//   Synchronous reset clears the sums, point count, queue and engine, and sets the
//   offset register to 8.
`timescale 1ns / 1ps

module face_similarity_transform_fit_unit #(
  parameter int NUM_POINTS = fstf_pkg::NUM_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [fstf_pkg::COORD_W-1:0]       in_x_coord,
  input  logic [fstf_pkg::COORD_W-1:0]       in_y_coord,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fstf_pkg::OFF_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic signed [fstf_pkg::COEF_W-1:0] out_fwd_a,
  output logic signed [fstf_pkg::COEF_W-1:0] out_fwd_b,
  output logic signed [fstf_pkg::COEF_W-1:0] out_fwd_tx,
  output logic signed [fstf_pkg::COEF_W-1:0] out_fwd_ty,
  output logic signed [fstf_pkg::COEF_W-1:0] out_inv_a,
  output logic signed [fstf_pkg::COEF_W-1:0] out_inv_b,
  output logic signed [fstf_pkg::COEF_W-1:0] out_inv_tx,
  output logic signed [fstf_pkg::COEF_W-1:0] out_inv_ty,
  output logic                               out_degenerate,
  output logic                               out_saturated
);
  import fstf_pkg::*;

  logic    q_push, q_full, q_pop, q_empty;
  set_t    q_din, q_dout;
  result_t res;

  fstf_front #(.NUM_POINTS(NUM_POINTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .x_coord   (in_x_coord),
    .y_coord   (in_y_coord),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_din)
  );

  fstf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  fstf_back #(.NUM_POINTS(NUM_POINTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_dout),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (out_valid)
  );

  assign out_fwd_a      = res.fwd_a;
  assign out_fwd_b      = res.fwd_b;
  assign out_fwd_tx     = res.fwd_tx;
  assign out_fwd_ty     = res.fwd_ty;
  assign out_inv_a      = res.inv_a;
  assign out_inv_b      = res.inv_b;
  assign out_inv_tx     = res.inv_tx;
  assign out_inv_ty     = res.inv_ty;
  assign out_degenerate = res.degenerate;
  assign out_saturated  = res.saturated;

endmodule
